/* hdl/tsq_pkg.sv */
`default_nettype none

package tsq_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned CAP_W     = 7;
   localparam int unsigned MOVED_W   = 7;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_INBOX_CAP  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTBOX_CAP = 1'b1;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic signed [WORD_W-1:0] NEG_ONE = -32'sd1;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_XFER,
      ST_FINISH,
      ST_POP,
      ST_RESULT
   } state_type;

   typedef struct packed {
      op_type                   req_type;
      logic signed [WORD_W-1:0] push_value;
   } req_word_type;

   typedef struct packed {
      status_type               status;
      logic signed [WORD_W-1:0] result_value;
      logic [MOVED_W-1:0]       moved_count;
   } rsp_word_type;

endpackage

`default_nettype wire

/* hdl/tsq_ram.sv */
`default_nettype none

module tsq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/two_stack_queue.sv */
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    req_word  (req_type, push_value)
// rsp      out        rsp_valid/rsp_ready    rsp_word  (status, result_value, moved_count)
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// one request at a time; a plain push, overflow or underflow goes through ST_RESULT to the
// output register, a plain pop through ST_POP and then ST_RESULT
// a transfer does one inbox read per cycle in ST_XFER, into the outbox while it has room,
// then goes to ST_FINISH; a dequeue that still finds the outbox empty skips ST_POP
// the output register holds a word while the next request is taken
// reset clears counts and state, capacities go to 64; stack memories are not cleared
// csr_ready is always high
`default_nettype none

module two_stack_queue #(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire tsq_pkg::req_word_type               req_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output tsq_pkg::rsp_word_type                    rsp_word,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tsq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tsq_pkg::CAP_W-1:0]           csr_data
);

   import tsq_pkg::*;

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;

   state_type          state_ff, state_in;
   logic [CW-1:0]      in_cnt_ff, in_cnt_in;
   logic [CW-1:0]      out_cnt_ff, out_cnt_in;
   logic [CAP_W-1:0]   in_cap_ff, in_cap_in;
   logic [CAP_W-1:0]   out_cap_ff, out_cap_in;
   logic [MOVED_W-1:0] moved_ff, moved_in;
   logic               is_deq_ff, is_deq_in;
   logic [WORD_W-1:0]  push_val_ff, push_val_in;
   rsp_word_type       res_ff, res_in;
   logic               wr_pend_ff, wr_pend_in;
   logic [AW-1:0]      wr_addr_ff, wr_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic [MW-1:0]      in_eff;
   logic [MW-1:0]      out_eff;
   logic               in_full;
   logic               out_full;
   logic [AW-1:0]      in_top;
   logic [AW-1:0]      out_top;
   logic               rsp_load;

   logic               in_wr_en;
   logic [AW-1:0]      in_wr_addr;
   logic [WORD_W-1:0]  in_wr_data;
   logic               in_rd_en;
   logic [WORD_W-1:0]  in_rd_data;
   logic               out_rd_en;
   logic [WORD_W-1:0]  out_rd_data;

   assign in_eff   = (MW'(in_cap_ff) > MW'(STACK_DEPTH)) ? MW'(STACK_DEPTH) : MW'(in_cap_ff);
   assign out_eff  = (MW'(out_cap_ff) > MW'(STACK_DEPTH)) ? MW'(STACK_DEPTH) : MW'(out_cap_ff);
   assign in_full  = MW'(in_cnt_ff) >= in_eff;
   assign out_full = MW'(out_cnt_ff) >= out_eff;
   assign in_top   = AW'(in_cnt_ff - CW'(1));
   assign out_top  = AW'(out_cnt_ff - CW'(1));

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      in_cap_in  = in_cap_ff;
      out_cap_in = out_cap_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_INBOX_CAP:  in_cap_in  = csr_data;
            CSR_OUTBOX_CAP: out_cap_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      in_cnt_in   = in_cnt_ff;
      out_cnt_in  = out_cnt_ff;
      moved_in    = moved_ff;
      is_deq_in   = is_deq_ff;
      push_val_in = push_val_ff;
      res_in      = res_ff;
      wr_pend_in  = 1'b0;
      wr_addr_in  = wr_addr_ff;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      in_wr_en    = 1'b0;
      in_wr_addr  = in_cnt_ff[AW-1:0];
      in_wr_data  = push_val_ff;
      in_rd_en    = 1'b0;
      out_rd_en   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               moved_in    = '0;
               push_val_in = req_word.push_value;
               if (req_word.req_type == OP_ENQUEUE) begin
                  is_deq_in = 1'b0;
                  if (in_full && out_cnt_ff == '0) begin
                     state_in = ST_XFER;
                  end else if (in_full) begin
                     res_in   = '{status: STATUS_OVERFLOW, result_value: '0, moved_count: '0};
                     state_in = ST_RESULT;
                  end else begin
                     in_wr_en   = 1'b1;
                     in_wr_data = req_word.push_value;
                     in_cnt_in  = in_cnt_ff + CW'(1);
                     res_in     = '{status: STATUS_DONE, result_value: req_word.push_value,
                                    moved_count: '0};
                     state_in   = ST_RESULT;
                  end
               end else begin
                  is_deq_in = 1'b1;
                  if (out_cnt_ff == '0 && in_cnt_ff != '0) begin
                     state_in = ST_XFER;
                  end else if (out_cnt_ff == '0) begin
                     res_in   = '{status: STATUS_UNDERFLOW, result_value: NEG_ONE,
                                  moved_count: '0};
                     state_in = ST_RESULT;
                  end else begin
                     out_rd_en  = 1'b1;
                     out_cnt_in = out_cnt_ff - CW'(1);
                     state_in   = ST_POP;
                  end
               end
            end
         end
         ST_XFER: begin
            if (in_cnt_ff != '0 && (is_deq_ff || !out_full)) begin
               in_rd_en  = 1'b1;
               in_cnt_in = in_cnt_ff - CW'(1);
               moved_in  = moved_ff + MOVED_W'(1);
               if (!out_full) begin
                  wr_pend_in = 1'b1;
                  wr_addr_in = out_cnt_ff[AW-1:0];
                  out_cnt_in = out_cnt_ff + CW'(1);
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!is_deq_ff) begin
               if (!in_full) begin
                  in_wr_en  = 1'b1;
                  in_cnt_in = in_cnt_ff + CW'(1);
               end
               res_in   = '{status: STATUS_DONE, result_value: push_val_ff,
                            moved_count: moved_ff};
               state_in = ST_RESULT;
            end else if (out_cnt_ff == '0) begin
               res_in   = '{status: STATUS_DONE, result_value: NEG_ONE, moved_count: moved_ff};
               state_in = ST_RESULT;
            end else begin
               out_rd_en  = 1'b1;
               out_cnt_in = out_cnt_ff - CW'(1);
               state_in   = ST_POP;
            end
         end
         ST_POP: begin
            res_in   = '{status: STATUS_DONE, result_value: out_rd_data, moved_count: moved_ff};
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_word_in  = rsp_word_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         in_cap_ff    <= CAP_RESET;
         out_cap_ff   <= CAP_RESET;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         in_cap_ff    <= in_cap_in;
         out_cap_ff   <= out_cap_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      moved_ff    <= moved_in;
      is_deq_ff   <= is_deq_in;
      push_val_ff <= push_val_in;
      res_ff      <= res_in;
      wr_addr_ff  <= wr_addr_in;
      rsp_word_ff <= rsp_word_in;
   end

   tsq_ram #(
      .WIDTH(WORD_W),
      .DEPTH(STACK_DEPTH)
   ) u_inbox_ram (
      .clock  (clock),
      .wr_en  (in_wr_en),
      .wr_addr(in_wr_addr),
      .wr_data(in_wr_data),
      .rd_en  (in_rd_en),
      .rd_addr(in_top),
      .rd_data(in_rd_data)
   );

   tsq_ram #(
      .WIDTH(WORD_W),
      .DEPTH(STACK_DEPTH)
   ) u_outbox_ram (
      .clock  (clock),
      .wr_en  (wr_pend_ff),
      .wr_addr(wr_addr_ff),
      .wr_data(in_rd_data),
      .rd_en  (out_rd_en),
      .rd_addr(out_top),
      .rd_data(out_rd_data)
   );

`ifndef SYNTHESIS
   a_finish_no_pending_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !wr_pend_ff)
      else $error("outbox write still pending when transfer finishes");

   a_write_follows_transfer: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> ($past(state_ff) == ST_XFER))
      else $error("outbox write without a transfer read");

   a_inbox_bound: assert property (@(posedge clock) disable iff (reset)
      in_cnt_ff <= CW'(STACK_DEPTH))
      else $error("inbox count beyond depth");

   a_outbox_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= CW'(STACK_DEPTH))
      else $error("outbox count beyond depth");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start processing");
`endif

endmodule

`default_nettype wire

/* test/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsq_pkg::*;

   localparam int DEPTH = 64;
   localparam int AW = $clog2(DEPTH);
   localparam int MAX_GAP = 11;
   localparam int RANDOM_ITEMS = 1000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES = 300;
   localparam int PRINT_LIMIT = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_INBOX_CAP;
   logic [CAP_W-1:0] csr_data = '0;

   two_stack_queue #(.STACK_DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // shadow copy of both stacks
   logic [WORD_W-1:0] inbox_mem [DEPTH];
   logic [WORD_W-1:0] outbox_mem [DEPTH];
   logic [CAP_W-1:0] inbox_fill = '0;
   logic [CAP_W-1:0] outbox_fill = '0;
   logic [CAP_W-1:0] inbox_cap = CAP_RESET;
   logic [CAP_W-1:0] outbox_cap = CAP_RESET;

   rsp_word_type queued_responses [$];
   int errors = 0;
   bit idle_on = 1'b1;
   int rsp_hold_request = 0;

   function automatic logic [CAP_W-1:0] limit_cap(input logic [CAP_W-1:0] cap);
      return (cap > DEPTH) ? CAP_W'(DEPTH) : cap;
   endfunction

   function automatic bit inbox_full();
      return inbox_fill >= limit_cap(inbox_cap);
   endfunction

   function automatic bit outbox_full();
      return outbox_fill >= limit_cap(outbox_cap);
   endfunction

   function automatic void inbox_push(input logic [WORD_W-1:0] value);
      if (!inbox_full() && inbox_fill < DEPTH) begin
         inbox_mem[inbox_fill[AW-1:0]] = value;
         inbox_fill++;
      end
   endfunction

   function automatic void outbox_push(input logic [WORD_W-1:0] value);
      if (!outbox_full() && outbox_fill < DEPTH) begin
         outbox_mem[outbox_fill[AW-1:0]] = value;
         outbox_fill++;
      end
   endfunction

   function automatic logic [WORD_W-1:0] inbox_pop();
      if (inbox_fill == 0) return NEG_ONE;
      inbox_fill--;
      return inbox_mem[inbox_fill[AW-1:0]];
   endfunction

   function automatic logic [WORD_W-1:0] outbox_pop();
      if (outbox_fill == 0) return NEG_ONE;
      outbox_fill--;
      return outbox_mem[outbox_fill[AW-1:0]];
   endfunction

   function automatic rsp_word_type serve_request(input req_word_type w);
      rsp_word_type r;
      r.status = STATUS_DONE;
      r.result_value = '0;
      r.moved_count = '0;
      if (w.req_type == OP_ENQUEUE) begin
         if (inbox_full() && outbox_fill == 0) begin
            while (inbox_fill != 0 && !outbox_full()) begin
               outbox_push(inbox_pop());
               r.moved_count++;
            end
            inbox_push(w.push_value);
            r.result_value = w.push_value;
         end else if (inbox_full()) begin
            r.status = STATUS_OVERFLOW;
         end else begin
            inbox_push(w.push_value);
            r.result_value = w.push_value;
         end
      end else begin
         if (outbox_fill == 0 && inbox_fill != 0) begin
            // items that find the outbox full are lost
            while (inbox_fill != 0) begin
               outbox_push(inbox_pop());
               r.moved_count++;
            end
            r.result_value = outbox_pop();
         end else if (outbox_fill == 0) begin
            r.status = STATUS_UNDERFLOW;
            r.result_value = NEG_ONE;
         end else begin
            r.result_value = outbox_pop();
         end
      end
      return r;
   endfunction

   function automatic int draw_gap();
      return idle_on ? $urandom_range(0, MAX_GAP) : 0;
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
   endtask

   task automatic send_word(input op_type op, input logic [WORD_W-1:0] value);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{req_type: op, push_value: value};
      do @(posedge clock); while (!(req_valid && req_ready));
      queued_responses.push_back(serve_request(req_word));
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CAP_W-1:0] data);
      req_valid <= 1'b0;
      do @(posedge clock); while (queued_responses.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (idx == CSR_INBOX_CAP) inbox_cap = data;
      else outbox_cap = data;
      csr_valid <= 1'b0;
   endtask

   task automatic set_capacities(input logic [CAP_W-1:0] in_cap,
                                 input logic [CAP_W-1:0] out_cap);
      write_register(CSR_INBOX_CAP, in_cap);
      write_register(CSR_OUTBOX_CAP, out_cap);
   endtask

   task automatic test_empty_and_extremes();
      send_word(OP_DEQUEUE, 32'h1234_5678);
      send_word(OP_ENQUEUE, 32'h8000_0000);
      send_word(OP_ENQUEUE, 32'h7FFF_FFFF);
      send_word(OP_ENQUEUE, 32'h0000_0000);
      send_word(OP_ENQUEUE, 32'hFFFF_FFFF);
      send_word(OP_DEQUEUE, 32'hFFFF_FFFF);
      send_word(OP_ENQUEUE, 32'hA5A5_A5A5);
      send_word(OP_DEQUEUE, 32'h0000_0000);
      send_word(OP_DEQUEUE, 32'h0000_0000);
      send_word(OP_DEQUEUE, 32'h0000_0000);
      send_word(OP_DEQUEUE, 32'h0000_0000);
      send_word(OP_DEQUEUE, 32'h0000_0000);
   endtask

   task automatic test_capacity_corners();
      set_capacities(7'd2, 7'd3);
      send_word(OP_ENQUEUE, 32'h0000_0011);
      send_word(OP_ENQUEUE, 32'h0000_0022);
      send_word(OP_ENQUEUE, 32'h0000_0033);
      send_word(OP_ENQUEUE, 32'h0000_0044);
      send_word(OP_ENQUEUE, 32'h0000_0055);
      send_word(OP_DEQUEUE, 32'h0000_0000);
      // shrink below the current fill
      set_capacities(7'd1, 7'd1);
      send_word(OP_ENQUEUE, 32'h0000_0066);
      set_capacities(7'd0, 7'd0);
      send_word(OP_DEQUEUE, 32'h0000_0000);
      send_word(OP_DEQUEUE, 32'h0000_0000);
      send_word(OP_ENQUEUE, 32'h0000_0077);
      set_capacities(7'd127, 7'd65);
      send_word(OP_ENQUEUE, 32'hDEAD_BEEF);
      send_word(OP_ENQUEUE, 32'h0BAD_F00D);
      send_word(OP_DEQUEUE, 32'h0000_0000);
   endtask

   task automatic test_full_transfer();
      set_capacities(CAP_RESET, CAP_RESET);
      while (outbox_fill != 0 || inbox_fill != 0) send_word(OP_DEQUEUE, $urandom());
      repeat (DEPTH + 1) send_word(OP_ENQUEUE, $urandom());
      repeat (DEPTH) send_word(OP_ENQUEUE, $urandom());
      send_word(OP_ENQUEUE, $urandom());
      repeat (2 * DEPTH + 2) send_word(OP_DEQUEUE, $urandom());
   endtask

   task automatic test_backpressure();
      set_capacities(7'd8, 7'd8);
      idle_on = 1'b0;
      rsp_hold_request = HOLD_CYCLES;
      repeat (20) send_word(($urandom_range(0, 1) != 0) ? OP_ENQUEUE : OP_DEQUEUE,
                            $urandom());
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int sent;
      int n;
      int enq_pct;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: set_capacities(CAP_RESET, CAP_RESET);
            1: set_capacities(CAP_W'($urandom_range(1, 8)), CAP_W'($urandom_range(1, 8)));
            2: set_capacities(CAP_W'($urandom_range(0, 127)),
                              CAP_W'($urandom_range(0, 127)));
            default: set_capacities(CAP_W'($urandom_range(1, 16)),
                                    CAP_W'($urandom_range(8, 64)));
         endcase
         enq_pct = 30 + 20 * $urandom_range(0, 3);
         idle_on = ($urandom_range(0, 3) != 0);
         n = $urandom_range(40, 90);
         repeat (n) begin
            send_word(($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                      $urandom());
         end
         sent += n;
      end
      idle_on = 1'b1;
   endtask

   // response side stalls
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (rsp_hold_request > 0) begin
            stall = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (queued_responses.size() == 0) begin
            report_mismatch("unexpected word", rsp_word.result_value, '0);
         end else begin
            want = queued_responses.pop_front();
            if (rsp_word.status !== want.status)
               report_mismatch("status", WORD_W'(rsp_word.status), WORD_W'(want.status));
            if (rsp_word.result_value !== want.result_value)
               report_mismatch("result_value", rsp_word.result_value, want.result_value);
            if (rsp_word.moved_count !== want.moved_count)
               report_mismatch("moved_count", WORD_W'(rsp_word.moved_count),
                               WORD_W'(want.moved_count));
         end
      end
   end

   initial begin
      #8ms;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      test_capacity_corners();
      test_full_transfer();
      test_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      do @(posedge clock); while (queued_responses.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/tsq_pkg.sv
hdl/tsq_ram.sv
hdl/two_stack_queue.sv
test/tb.sv
